>>> hw/rtl/two_hop_neighbor_matrix_core_assert.svh
// Assertion macros used by the RTL of the two-hop neighbor block.
`ifndef TWO_HOP_NEIGHBOR_MATRIX_CORE_ASSERT_SVH
`define TWO_HOP_NEIGHBOR_MATRIX_CORE_ASSERT_SVH

// Plain property, checked on the rising clock edge outside reset.
`define TNM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Overlapping implication: a |-> b.
`define TNM_ASSERT_IMP(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication: a |=> b.
`define TNM_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

>>> hw/rtl/tnm_pkg.sv
package tnm_pkg;

  localparam int DATA_W        = 64;
  localparam int NC_W          = 7;
  localparam int ROW_W         = 6;
  localparam int MAX_NODES_DEF = 64;
  localparam logic [NC_W-1:0] NODE_COUNT_RST = NC_W'(64);

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_LOAD,
    CELL_INIT_A,
    CELL_STEP_A,
    CELL_INIT_B,
    CELL_STEP_B,
    CELL_SHIFT_OUT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [ROW_W-1:0]   load_idx;
    logic [DATA_W-1:0]  mask;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_INIT_A,
    S_RUN_A,
    S_INIT_B,
    S_RUN_B,
    S_EMIT
  } state_t;

endpackage

>>> hw/rtl/tnm_in_if.sv
interface tnm_in_if;
  logic                        valid;
  logic                        ready;
  logic [tnm_pkg::DATA_W-1:0]  adjacency_row;

  modport source (output valid, output adjacency_row, input ready);
  modport sink   (input valid, input adjacency_row, output ready);
endinterface

>>> hw/rtl/tnm_out_if.sv
interface tnm_out_if;
  logic                        valid;
  logic                        ready;
  logic [tnm_pkg::ROW_W-1:0]   row_index;
  logic [tnm_pkg::DATA_W-1:0]  candidate_row;
  logic                        last_row;

  modport source (output valid, output row_index, output candidate_row, output last_row,
                  input ready);
  modport sink   (input valid, input row_index, input candidate_row, input last_row,
                  output ready);
endinterface

>>> hw/rtl/tnm_cfg_if.sv
interface tnm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tnm_pkg::NC_W-1:0]  node_count;

  modport source (output valid, output node_count, input ready);
  modport sink   (input valid, input node_count, output ready);
endinterface

>>> hw/rtl/tnm_cell.sv
// One person of the matrix: holds its adjacency row, its reach, its
// candidate row, and a traveling word that moves one cell per step.
module tnm_cell #(
  parameter int MAX_NODES = tnm_pkg::MAX_NODES_DEF,
  parameter int IDX       = 0
) (
  input  logic                              clk,
  input  tnm_pkg::cell_ctl_t                ctl,
  input  logic [tnm_pkg::DATA_W-1:0]        load_data,
  input  logic [tnm_pkg::DATA_W-1:0]        trav_in_row,
  input  logic [$clog2(MAX_NODES)-1:0]      trav_in_idx,
  input  logic [tnm_pkg::DATA_W-1:0]        res_in,
  output logic [tnm_pkg::DATA_W-1:0]        trav_row,
  output logic [$clog2(MAX_NODES)-1:0]      trav_idx,
  output logic [tnm_pkg::DATA_W-1:0]        res
);

  localparam int IW = $clog2(MAX_NODES);
  localparam logic [tnm_pkg::ROW_W-1:0] MY_ROW = tnm_pkg::ROW_W'(IDX);
  localparam logic [IW-1:0]             MY_IDX = IW'(IDX);
  localparam logic [tnm_pkg::DATA_W-1:0] SELF = tnm_pkg::DATA_W'(1) << IDX;

  logic [tnm_pkg::DATA_W-1:0] row;
  logic [tnm_pkg::DATA_W-1:0] acc;
  logic [tnm_pkg::DATA_W-1:0] cand;

  // new candidates: reached in two hops, not yet a friend, not self
  assign cand = acc & ~row & ~SELF & ctl.mask;

  always_ff @(posedge clk) begin
    case (ctl.op)
      tnm_pkg::CELL_LOAD: begin
        if (ctl.load_idx == MY_ROW) row <= load_data & ctl.mask;
      end
      tnm_pkg::CELL_INIT_A: begin
        acc      <= '0;
        trav_row <= row;
        trav_idx <= MY_IDX;
      end
      tnm_pkg::CELL_STEP_A: begin
        // friend j's row passes by: fold it into the reach
        if (row[trav_idx]) acc <= acc | trav_row;
        trav_row <= trav_in_row;
        trav_idx <= trav_in_idx;
      end
      tnm_pkg::CELL_INIT_B: begin
        res      <= cand;
        // cells past the node count hold stale rows: keep them out of the mirror
        trav_row <= ctl.mask[IDX] ? cand : '0;
        trav_idx <= MY_IDX;
      end
      tnm_pkg::CELL_STEP_B: begin
        // candidate row j names this cell: mirror the bit
        if (trav_row[IDX]) res[trav_idx] <= 1'b1;
        trav_row <= trav_in_row;
        trav_idx <= trav_in_idx;
      end
      tnm_pkg::CELL_SHIFT_OUT: begin
        res <= res_in;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/two_hop_neighbor_matrix_core.sv
// Two-hop neighbor matrix. Load node_count rows of the adjacency matrix,
// one word per row; the last row starts a run on a ring of MAX_NODES
// cells, one per person. Each row circulates once around the ring to
// build the reach, then each candidate row circulates once to make the
// result symmetric, and the node_count result rows shift out of cell 0
// at one word per cycle while the sink is ready. Input is not taken
// during the compute and emit phases; writing node_count drops a
// partial load.
`include "two_hop_neighbor_matrix_core_assert.svh"

module two_hop_neighbor_matrix_core #(
  parameter int MAX_NODES = tnm_pkg::MAX_NODES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  tnm_cfg_if.sink      cfg,
  tnm_in_if.sink       adj_in,
  tnm_out_if.source    cand_out
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [CW-1:0] N_MAX = CW'(MAX_NODES);
  localparam logic [IW-1:0] STEP_LAST = IW'(MAX_NODES - 1);

  tnm_pkg::state_t state, state_next;
  tnm_pkg::cell_ctl_t ctl;

  logic [tnm_pkg::NC_W-1:0] node_count;
  logic [CW-1:0]            n_eff;
  logic [CW-1:0]            load_cnt;
  logic [CW-1:0]            emit_cnt;
  logic [IW-1:0]            step;
  logic [tnm_pkg::DATA_W-1:0] mask;

  logic                       out_valid;
  logic [tnm_pkg::ROW_W-1:0]  out_idx;
  logic [tnm_pkg::DATA_W-1:0] out_row;
  logic                       out_last;

  logic in_acc, out_take, last_load, last_emit, step_end;

  logic [tnm_pkg::DATA_W-1:0] trav_row [MAX_NODES];
  logic [IW-1:0]              trav_idx [MAX_NODES];
  logic [tnm_pkg::DATA_W-1:0] res      [MAX_NODES];

  // effective count clamped to 1..MAX_NODES
  always_comb begin
    if (node_count == '0) n_eff = CW'(1);
    else if ({1'b0, node_count} > (tnm_pkg::NC_W+1)'(MAX_NODES)) n_eff = N_MAX;
    else n_eff = CW'(node_count);
  end

  always_comb begin
    for (int k = 0; k < tnm_pkg::DATA_W; k++) mask[k] = (k < int'(n_eff));
  end

  assign cfg.ready    = 1'b1;
  assign adj_in.ready = (state == tnm_pkg::S_LOAD);
  assign in_acc       = adj_in.valid && adj_in.ready;
  assign last_load    = (load_cnt + CW'(1) == n_eff);
  assign step_end     = (step == STEP_LAST);
  assign out_take     = (state == tnm_pkg::S_EMIT) && (!out_valid || cand_out.ready);
  assign last_emit    = (emit_cnt + CW'(1) == n_eff);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tnm_pkg::S_LOAD:   if (in_acc && last_load) state_next = tnm_pkg::S_INIT_A;
      tnm_pkg::S_INIT_A: state_next = tnm_pkg::S_RUN_A;
      tnm_pkg::S_RUN_A:  if (step_end) state_next = tnm_pkg::S_INIT_B;
      tnm_pkg::S_INIT_B: state_next = tnm_pkg::S_RUN_B;
      tnm_pkg::S_RUN_B:  if (step_end) state_next = tnm_pkg::S_EMIT;
      tnm_pkg::S_EMIT:   if (out_take && last_emit) state_next = tnm_pkg::S_LOAD;
      default:           state_next = tnm_pkg::S_LOAD;
    endcase
  end

  // cell command
  always_comb begin
    ctl.load_idx = tnm_pkg::ROW_W'(load_cnt);
    ctl.mask     = mask;
    ctl.op       = tnm_pkg::CELL_IDLE;
    unique case (state)
      tnm_pkg::S_LOAD:   if (in_acc) ctl.op = tnm_pkg::CELL_LOAD;
      tnm_pkg::S_INIT_A: ctl.op = tnm_pkg::CELL_INIT_A;
      tnm_pkg::S_RUN_A:  ctl.op = tnm_pkg::CELL_STEP_A;
      tnm_pkg::S_INIT_B: ctl.op = tnm_pkg::CELL_INIT_B;
      tnm_pkg::S_RUN_B:  ctl.op = tnm_pkg::CELL_STEP_B;
      tnm_pkg::S_EMIT:   if (out_take) ctl.op = tnm_pkg::CELL_SHIFT_OUT;
      default:           ctl.op = tnm_pkg::CELL_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tnm_pkg::S_LOAD;
      node_count <= tnm_pkg::NODE_COUNT_RST;
      load_cnt   <= '0;
      emit_cnt   <= '0;
      step       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        node_count <= cfg.node_count;
        load_cnt   <= '0;
      end else if (in_acc) begin
        load_cnt <= last_load ? '0 : load_cnt + CW'(1);
      end
      if (state == tnm_pkg::S_INIT_A || state == tnm_pkg::S_INIT_B) step <= '0;
      else step <= step + IW'(1);
      if (state == tnm_pkg::S_INIT_A) emit_cnt <= '0;
      else if (out_take) emit_cnt <= emit_cnt + CW'(1);
      if (out_take) out_valid <= 1'b1;
      else if (cand_out.ready) out_valid <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (out_take) begin
      out_idx  <= tnm_pkg::ROW_W'(emit_cnt);
      out_row  <= res[0];
      out_last <= last_emit;
    end
  end

  assign cand_out.valid         = out_valid;
  assign cand_out.row_index     = out_idx;
  assign cand_out.candidate_row = out_row;
  assign cand_out.last_row      = out_last;

  // ring of cells
  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    localparam int PREV = (i + MAX_NODES - 1) % MAX_NODES;
    logic [tnm_pkg::DATA_W-1:0] res_in;
    if (i == MAX_NODES - 1) begin : g_tail
      assign res_in = '0;
    end else begin : g_mid
      assign res_in = res[i+1];
    end
    tnm_cell #(.MAX_NODES(MAX_NODES), .IDX(i)) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .load_data   (adj_in.adjacency_row),
      .trav_in_row (trav_row[PREV]),
      .trav_in_idx (trav_idx[PREV]),
      .res_in      (res_in),
      .trav_row    (trav_row[i]),
      .trav_idx    (trav_idx[i]),
      .res         (res[i])
    );
  end

  `TNM_ASSERT(a_load_in_range, clk, rst, load_cnt < n_eff, "load counter past node count")
  `TNM_ASSERT_IMP(a_emit_in_range, clk, rst, state == tnm_pkg::S_EMIT, emit_cnt < n_eff, "emit count past node count")
  `TNM_ASSERT_NEXT(a_last_ends_run, clk, rst, cand_out.valid && cand_out.ready && cand_out.last_row, !cand_out.valid, "word after last row")

endmodule

>>> sim/tb_two_hop_neighbor_matrix_core_checker.sv
module tb_two_hop_neighbor_matrix_core_checker (
  input  logic      clk,
  input  logic      rst,
  tnm_cfg_if.sink   cfg_mon,
  tnm_in_if.sink    in_mon,
  tnm_out_if.sink   out_mon,
  output int        fail_count,
  output int        rows_pending
);

  localparam int EXP_DEPTH = 128;

  typedef logic [tnm_pkg::DATA_W-1:0] word_t;

  typedef struct packed {
    logic [tnm_pkg::ROW_W-1:0]  row_index;
    logic [tnm_pkg::DATA_W-1:0] candidate_row;
    logic                       last_row;
  } cand_word_t;

  logic [tnm_pkg::NC_W-1:0] node_count_q;
  word_t                    adj_rows [tnm_pkg::MAX_NODES_DEF];
  int                       load_ptr;
  cand_word_t               exp_fifo [EXP_DEPTH];
  int                       exp_wr = 0;
  int                       exp_rd = 0;

  assign rows_pending = exp_wr - exp_rd;

  function automatic int people(input logic [tnm_pkg::NC_W-1:0] nc);
    if (nc == 0) return 1;
    if (nc > tnm_pkg::MAX_NODES_DEF) return tnm_pkg::MAX_NODES_DEF;
    return nc;
  endfunction

  function automatic word_t people_mask(input int n);
    if (n >= tnm_pkg::DATA_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // compute candidate matrix, symmetrize, queue the result words
  task automatic predict_candidates(input int n);
    word_t      m;
    word_t      t [tnm_pkg::MAX_NODES_DEF];
    word_t      reach;
    word_t      r;
    cand_word_t w;
    m = people_mask(n);
    for (int i = 0; i < n; i++) begin
      reach = '0;
      for (int j = 0; j < n; j++)
        if (adj_rows[i][j]) reach |= adj_rows[j];
      t[i] = reach & ~adj_rows[i] & ~(64'd1 << i) & m;
    end
    for (int i = 0; i < n; i++) begin
      r = t[i];
      for (int j = 0; j < n; j++)
        if (t[j][i]) r[j] = 1'b1;
      w.row_index = tnm_pkg::ROW_W'(i);
      w.candidate_row = r & m;
      w.last_row = (i == n - 1);
      exp_fifo[exp_wr % EXP_DEPTH] = w;
      exp_wr++;
    end
  endtask

  task automatic report(input string what, input word_t got, input word_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // sample all channels on the rising edge
  always @(posedge clk) begin
    cand_word_t w;
    int n;
    if (rst) begin
      node_count_q <= tnm_pkg::NODE_COUNT_RST;
      load_ptr = 0;
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        node_count_q <= cfg_mon.node_count;
        load_ptr = 0;
      end
      if (in_mon.valid && in_mon.ready) begin
        n = people(node_count_q);
        adj_rows[load_ptr] = in_mon.adjacency_row & people_mask(n);
        load_ptr++;
        if (load_ptr >= n) begin
          load_ptr = 0;
          predict_candidates(n);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (exp_wr == exp_rd) begin
          report("unexpected word", out_mon.candidate_row, '0);
        end else begin
          w = exp_fifo[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_mon.row_index !== w.row_index)
            report("row_index", word_t'(out_mon.row_index), word_t'(w.row_index));
          if (out_mon.candidate_row !== w.candidate_row)
            report("candidate_row", out_mon.candidate_row, w.candidate_row);
          if (out_mon.last_row !== w.last_row)
            report("last_row", word_t'(out_mon.last_row), word_t'(w.last_row));
        end
      end
    end
  end
endmodule

>>> sim/tb_two_hop_neighbor_matrix_core.sv
module tb_two_hop_neighbor_matrix_core;

  localparam int CYCLE_LIMIT = 1500000;

  typedef logic [tnm_pkg::DATA_W-1:0] word_t;
  typedef logic [tnm_pkg::NC_W-1:0]   count_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   rows_pending;
  int   cycle_count = 0;
  bit   quiet_phase = 1'b0;
  int   sink_hold = 0;

  tnm_cfg_if cfg ();
  tnm_in_if  adj_in ();
  tnm_out_if cand_out ();

  two_hop_neighbor_matrix_core uut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .adj_in(adj_in.sink), .cand_out(cand_out.source)
  );

  tb_two_hop_neighbor_matrix_core_checker chk (
    .clk(clk), .rst(rst), .cfg_mon(cfg.sink), .in_mon(adj_in.sink),
    .out_mon(cand_out.sink), .fail_count(fail_count), .rows_pending(rows_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // sink backpressure in bursts
  always @(negedge clk) begin
    if (rst || quiet_phase) begin
      cand_out.ready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      cand_out.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      sink_hold <= $urandom_range(0, 13);
      cand_out.ready <= 1'b0;
    end else begin
      cand_out.ready <= 1'b1;
    end
  end

  // valid stays up across back-to-back rows; it drops for an idle burst
  task automatic send_row(input word_t row);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      adj_in.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    adj_in.valid <= 1'b1;
    adj_in.adjacency_row <= row;
    do @(posedge clk); while (!adj_in.ready);
    @(negedge clk);
  endtask

  task automatic stop_rows();
    adj_in.valid <= 1'b0;
  endtask

  // write only when no result word is outstanding
  task automatic set_count(input count_t nc);
    stop_rows();
    while (rows_pending != 0) @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.node_count <= nc;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic word_t rand_word(input int density);
    word_t w;
    w = '0;
    for (int b = 0; b < tnm_pkg::DATA_W; b++)
      w[b] = ($urandom_range(0, 99) < density);
    return w;
  endfunction

  task automatic send_matrix(input int n, input int density);
    for (int i = 0; i < n; i++) send_row(rand_word(density));
  endtask

  int n;
  int sent;

  initial begin
    cfg.valid = 1'b0;
    cfg.node_count = '0;
    adj_in.valid = 1'b0;
    adj_in.adjacency_row = '0;
    cand_out.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset count of 64, directed cycle graph with self loops
    for (int i = 0; i < 64; i++)
      send_row((64'd1 << i) | (64'd1 << ((i + 1) % 64)));
    // node count zero behaves as one, all-ones row
    set_count(7'd0);
    send_row('1);
    // above maximum clamps to 64
    set_count(7'd127);
    send_matrix(64, 3);
    // small graph: a mutual pair, then an all-ones row and a zero row
    set_count(7'd4);
    send_row(64'h2);
    send_row(64'h1);
    send_row('1);
    send_row('0);
    // count written mid-load drops partial rows
    set_count(7'd3);
    send_row('1);
    set_count(7'd2);
    send_row(64'h2);
    send_row(64'h1);

    // random: mostly small sizes, a few large ones
    sent = 0;
    while (sent < 340) begin
      if (sent > 280) quiet_phase = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 12);
      set_count(count_t'(n));
      if ($urandom_range(0, 9) == 0 && n > 1) begin
        send_matrix($urandom_range(1, n - 1), 30);
        set_count(count_t'(n));
      end
      send_matrix(n, $urandom_range(0, 100));
      sent += n;
    end

    stop_rows();
    while (rows_pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
